>>> hdl/tld_pkg.sv
// Package for the terminal line discipline: control states, command and
// status structures and character constants. No dependencies.
`timescale 1ns / 1ps
package tld_pkg;

    localparam logic [7:0] C_CH_BS  = 8'd8;
    localparam logic [7:0] C_CH_DEL = 8'd127;
    localparam logic [7:0] C_CH_LF  = 8'd10;
    localparam logic [7:0] C_CH_CR  = 8'd13;
    localparam logic [7:0] C_CH_SP  = 8'd32;

    localparam logic [1:0] C_KIND_ECHO  = 2'd0;
    localparam logic [1:0] C_KIND_DATA  = 2'd1;
    localparam logic [1:0] C_KIND_EMPTY = 2'd2;

    localparam logic [1:0] C_REG_ACTIVE = 2'd0;
    localparam logic [1:0] C_REG_ECHO   = 2'd1;
    localparam logic [1:0] C_REG_CANON  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_COMMIT_RD,
        S_COMMIT_WR,
        S_READ_RD,
        S_READ_OUT,
        S_ECHO,
        S_EMPTY
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       latch_item;   // capture the accepted input item
        logic       line_store;   // store char_in at line_length, increment
        logic       line_nl;      // store newline at clamped length, set commit count
        logic       line_dec;     // decrement line length
        logic       line_clear;   // zero line length
        logic       raw_push;     // push char_in into the ring
        logic       commit_rd;    // read line store at commit index
        logic       commit_push;  // push line byte read into ring, advance index
        logic       ring_rd;      // read ring at read pointer
        logic       ring_pop;     // advance read pointer, count one
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic       func;
        logic       term_ok;
        logic       active;
        logic       echo;
        logic       canon;
        logic       is_bs;
        logic       is_nl;
        logic       line_empty;
        logic       line_room;
        logic       ring_empty;
        logic       commit_done;
        logic       read_stop;   // after this byte no more is returned
        logic [7:0] char_in;
        logic [7:0] ring_byte;
    } t_status;

endpackage

>>> hdl/tld_datapath.sv
// Datapath of the terminal line discipline: item register, pointers,
// line lengths, line store and ring memories. Depends on tld_pkg.
`timescale 1ns / 1ps
module tld_datapath #(
    parameter int TERMINALS  = 4,
    parameter int RING_DEPTH = 4096,
    parameter int LINE_DEPTH = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tld_pkg::t_cmd   i_cmd,
    output tld_pkg::t_status o_status,
    input  logic            i_func,
    input  logic [1:0]      i_terminal,
    input  logic [7:0]      i_char_in,
    input  logic [6:0]      i_read_count,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [3:0]      i_cfg_data
);
    import tld_pkg::*;

    localparam int TW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
    localparam int RW = $clog2(RING_DEPTH);
    localparam int LW = $clog2(LINE_DEPTH);
    localparam int CW = LW + 1;

    logic [3:0] r_active, r_echo, r_canon;
    logic       r_func;
    logic [1:0] r_term;
    logic [7:0] r_char;
    logic [6:0] r_count;
    logic [6:0] r_got;

    logic [RW-1:0] r_rp [TERMINALS];
    logic [RW-1:0] r_wp [TERMINALS];
    logic [LW-1:0] r_len [TERMINALS];

    logic [7:0] r_ring [TERMINALS*RING_DEPTH];
    logic [7:0] r_line [TERMINALS*LINE_DEPTH];
    logic [7:0] r_ring_q;
    logic [7:0] r_line_q;

    logic [CW-1:0] r_cidx;
    logic [CW-1:0] r_clen;

    logic [TW-1:0] w_t;
    logic          w_term_ok;
    logic [RW-1:0] w_rp, w_wp, w_wp_nx;
    logic [LW-1:0] w_len;
    logic          w_push;
    logic [7:0]    w_push_byte;
    logic [LW-1:0] w_nl_pos;
    logic [6:0]    w_cnt_cl;

    assign w_t       = TW'(r_term);
    assign w_term_ok = (32'(r_term) < TERMINALS);
    assign w_rp      = r_rp[w_t];
    assign w_wp      = r_wp[w_t];
    assign w_wp_nx   = w_wp + RW'(1);
    assign w_len     = r_len[w_t];
    assign w_nl_pos  = (32'(w_len) > LINE_DEPTH - 1) ? LW'(LINE_DEPTH - 1) : w_len;
    assign w_cnt_cl  = (r_count == 7'd0) ? 7'd1 : ((r_count > 7'd64) ? 7'd64 : r_count);
    assign w_push      = i_cmd.raw_push || i_cmd.commit_push;
    assign w_push_byte = i_cmd.raw_push ? r_char : r_line_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 4'd1;
            r_echo   <= 4'd15;
            r_canon  <= 4'd15;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                C_REG_ACTIVE: r_active <= i_cfg_data;
                C_REG_ECHO:   r_echo   <= i_cfg_data;
                C_REG_CANON:  r_canon  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_func  <= i_func;
            r_term  <= i_terminal;
            r_char  <= i_char_in;
            r_count <= i_read_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TERMINALS; k++) begin
                r_rp[k]  <= '0;
                r_wp[k]  <= '0;
                r_len[k] <= '0;
            end
            r_got  <= '0;
            r_cidx <= '0;
            r_clen <= '0;
        end else begin
            if (i_cmd.latch_item) r_got <= '0;
            if (i_cmd.ring_pop) begin
                r_rp[w_t] <= w_rp + RW'(1);
                r_got     <= r_got + 7'd1;
            end
            if (w_push && (w_wp_nx != w_rp)) r_wp[w_t] <= w_wp_nx;
            if (i_cmd.line_store) r_len[w_t] <= w_len + LW'(1);
            if (i_cmd.line_dec)   r_len[w_t] <= w_len - LW'(1);
            if (i_cmd.line_clear) r_len[w_t] <= '0;
            if (i_cmd.line_nl) begin
                r_cidx <= '0;
                r_clen <= CW'(w_nl_pos) + CW'(1);
            end
            if (i_cmd.commit_push) r_cidx <= r_cidx + CW'(1);
        end
    end

    // Line store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.line_store)
            r_line[{w_t, w_len}] <= r_char;
        else if (i_cmd.line_nl)
            r_line[{w_t, w_nl_pos}] <= C_CH_LF;
        if (i_cmd.commit_rd)
            r_line_q <= r_line[{w_t, r_cidx[LW-1:0]}];
    end

    // Ring store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_push && (w_wp_nx != w_rp))
            r_ring[{w_t, w_wp}] <= w_push_byte;
        if (i_cmd.ring_rd)
            r_ring_q <= r_ring[{w_t, w_rp}];
    end

    always_comb begin
        o_status.func        = r_func;
        o_status.term_ok     = w_term_ok;
        o_status.active      = w_term_ok && r_active[r_term];
        o_status.echo        = r_echo[r_term];
        o_status.canon       = r_canon[r_term];
        o_status.is_bs       = (r_char == C_CH_BS) || (r_char == C_CH_DEL);
        o_status.is_nl       = (r_char == C_CH_LF) || (r_char == C_CH_CR);
        o_status.line_empty  = (w_len == '0);
        o_status.line_room   = (32'(w_len) < LINE_DEPTH - 2);
        o_status.ring_empty  = (w_rp == w_wp);
        o_status.commit_done = (r_cidx == r_clen);
        o_status.read_stop   = (r_got + 7'd1 >= w_cnt_cl) || (w_rp + RW'(1) == w_wp)
                               || (r_canon[r_term] && r_ring_q == C_CH_LF);
        o_status.char_in     = r_char;
        o_status.ring_byte   = r_ring_q;
    end

endmodule

>>> hdl/tld_ctrl.sv
// Controller state machine of the terminal line discipline: sequences each
// transaction and drives the result port. Depends on tld_pkg.
`timescale 1ns / 1ps
module tld_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic             o_last,
    output tld_pkg::t_cmd    o_cmd,
    input  tld_pkg::t_status i_status
);
    import tld_pkg::*;

    t_state     r_state, n_state;
    logic       r_valid, n_valid;
    logic [1:0] r_kind, n_kind;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic [1:0] r_echo_cnt, n_echo_cnt;   // remaining echo bytes after the current one

    logic w_out_free;
    assign w_out_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_echo_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_echo_cnt <= n_echo_cnt;
        end
        r_kind <= n_kind;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid && i_stall;
        n_kind     = r_kind;
        n_byte     = r_byte;
        n_last     = r_last;
        n_echo_cnt = r_echo_cnt;
        o_cmd      = '0;
        o_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.latch_item = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.func) begin
                    if (!i_status.term_ok || i_status.ring_empty) begin
                        n_state = S_EMPTY;
                    end else begin
                        o_cmd.ring_rd = 1'b1;
                        n_state = S_READ_OUT;
                    end
                end else if (!i_status.active) begin
                    n_state = S_IDLE;
                end else if (!i_status.canon) begin
                    o_cmd.raw_push = 1'b1;
                    n_echo_cnt = 2'd0;
                    n_state = i_status.echo ? S_ECHO : S_IDLE;
                end else if (i_status.is_bs) begin
                    if (i_status.line_empty) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.line_dec = 1'b1;
                        n_echo_cnt = 2'd2;
                        n_state = i_status.echo ? S_ECHO : S_IDLE;
                    end
                end else if (i_status.is_nl) begin
                    o_cmd.line_nl = 1'b1;
                    n_state = S_COMMIT_RD;
                end else if (i_status.line_room) begin
                    o_cmd.line_store = 1'b1;
                    n_echo_cnt = 2'd0;
                    n_state = i_status.echo ? S_ECHO : S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_COMMIT_RD: begin
                if (i_status.commit_done) begin
                    o_cmd.line_clear = 1'b1;
                    n_echo_cnt = 2'd0;
                    n_state = i_status.echo ? S_ECHO : S_IDLE;
                end else begin
                    o_cmd.commit_rd = 1'b1;
                    n_state = S_COMMIT_WR;
                end
            end
            S_COMMIT_WR: begin
                o_cmd.commit_push = 1'b1;
                n_state = S_COMMIT_RD;
            end
            S_ECHO: begin
                if (w_out_free) begin
                    n_valid = 1'b1;
                    n_kind  = C_KIND_ECHO;
                    n_last  = (r_echo_cnt == 2'd0);
                    if (!i_status.canon)
                        n_byte = i_status.char_in;
                    else if (i_status.is_bs)
                        n_byte = (r_echo_cnt == 2'd1) ? C_CH_SP : C_CH_BS;
                    else if (i_status.is_nl)
                        n_byte = C_CH_LF;
                    else
                        n_byte = i_status.char_in;
                    if (r_echo_cnt == 2'd0)
                        n_state = S_IDLE;
                    else
                        n_echo_cnt = r_echo_cnt - 2'd1;
                end
            end
            S_READ_RD: begin
                o_cmd.ring_rd = 1'b1;
                n_state = S_READ_OUT;
            end
            S_READ_OUT: begin
                if (w_out_free) begin
                    n_valid = 1'b1;
                    n_kind  = C_KIND_DATA;
                    n_byte  = i_status.ring_byte;
                    n_last  = i_status.read_stop;
                    o_cmd.ring_pop = 1'b1;
                    n_state = i_status.read_stop ? S_IDLE : S_READ_RD;
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_valid = 1'b1;
                    n_kind  = C_KIND_EMPTY;
                    n_byte  = 8'd0;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_data_byte = r_byte;
    assign o_last      = r_last;

    // A result never overwrites one that is still stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_byte) && $stable(r_kind))
        else $error("stalled result changed");
    // An input is only taken in the idle state.
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> r_state == S_IDLE)
        else $error("input taken while busy");
    // The empty answer is always the last result of its transaction.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == C_KIND_EMPTY |-> r_last)
        else $error("empty result not last");

endmodule

>>> hdl/tty_line_discipline.sv
// Top level of the terminal line discipline: joins controller and datapath.
// Depends on tld_pkg, tld_ctrl and tld_datapath.
//
// Usage: input transactions carry func, terminal, char_in and read_count on
// i_valid / o_stall; results carry kind, data_byte and last on o_valid /
// i_stall. A newline in canonical mode walks the stored line byte by byte
// (line store read, then ring write). A read request fetches each byte
// through the single registered ring read port. One item is handled at a
// time.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data;
// the user must write it only while idle; the block does not enforce this.
// Reset clears pointers and line lengths and returns the masks to their
// defaults; the ring and line memories are not cleared and need no clearing
// pass. When the receiver stalls, the result register holds and the
// controller waits before giving its next result.
`timescale 1ns / 1ps
module tty_line_discipline #(
    parameter int TERMINALS  = 4,
    parameter int RING_DEPTH = 4096,
    parameter int LINE_DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_func,
    input  logic [1:0] i_terminal,
    input  logic [7:0] i_char_in,
    input  logic [6:0] i_read_count,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);
    import tld_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    tld_datapath #(
        .TERMINALS  (TERMINALS),
        .RING_DEPTH (RING_DEPTH),
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_func       (i_func),
        .i_terminal   (i_terminal),
        .i_char_in    (i_char_in),
        .i_read_count (i_read_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

endmodule
